[rtl/sac_pkg.sv]
// Shared types and constants for the set-associative LRU cache simulator.
// No dependencies; imported by sac_ctrl, sac_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

   // default geometry
   localparam int SETS_DEF = 64;
   localparam int WAYS_DEF = 8;

   // fixed field widths
   localparam int ADDR_W   = 64;
   localparam int CMD_W    = 2;
   localparam int CNT_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int SETB_W   = 3;
   localparam int BLKB_W   = 6;
   localparam int USED_W   = 4;

   // masked set value before the fold onto the set count
   localparam int SET_RAW_W = 7;
   localparam int SET_TAB_N = 1 << SET_RAW_W;

   localparam logic [CNT_W-1:0] CNT_MAX = 32'hffff_ffff;

   // access kinds
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_USED  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic capture;   // accept the request transaction, launch the row read
      logic decide;    // row data present, resolve hit / fill / victim
      logic commit;    // write the row back, update totals, load the response
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy;  // response register full and not draining
   } dp_status_type;

endpackage : sac_pkg

`default_nettype wire

[rtl/sac_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int ADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    we,
   input  wire logic [ADR_W-1:0]        waddr,
   input  wire logic [WIDTH-1:0]        wdata,
   input  wire logic                    re,
   input  wire logic [ADR_W-1:0]        raddr,
   output logic      [WIDTH-1:0]        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule : sac_ram

`default_nettype wire

[rtl/sac_ctrl.sv]
// Sequencing controller for the cache simulator: accept, lookup, update.
// Depends on sac_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sac_ctrl
   import sac_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   // commands
   always_comb begin
      cmd.capture = req_tvalid & ready_ff;
      cmd.decide  = (state_ff == ST_LOOKUP);
      cmd.commit  = (state_ff == ST_UPDATE) & ~status.out_busy;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid & ready_ff) begin
               state_in = ST_LOOKUP;
               ready_in = 1'b0;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (~status.out_busy) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule : sac_ctrl

`default_nettype wire

[rtl/sac_dp.sv]
// Datapath of the cache simulator: address split, set row store, way search,
// recency update, saturating totals and response register.
// Depends on sac_pkg and sac_ram.
`timescale 1ns / 1ps
`default_nettype none

module sac_dp
   import sac_pkg::*;
#(
   parameter int SETS = SETS_DEF,
   parameter int WAYS = WAYS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // configuration
   input  wire logic                    csr_valid,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data,
   // request payload
   input  wire logic [CMD_W-1:0]        req_command,
   input  wire logic [ADDR_W-1:0]       req_address,
   // response
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_was_hit,
   output logic                         rsp_was_eviction,
   output logic [CNT_W-1:0]             rsp_total_hits,
   output logic [CNT_W-1:0]             rsp_total_misses,
   output logic [CNT_W-1:0]             rsp_total_evictions,
   // control
   input  wire ctrl_cmd_type            cmd,
   output dp_status_type                status
);

   localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AGE_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ENTRY_W = ADDR_W + AGE_W + 1;
   localparam int ROW_W   = WAYS * ENTRY_W;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

   // configuration registers
   logic [SETB_W-1:0] set_bits_ff;
   logic [BLKB_W-1:0] block_bits_ff;
   logic [USED_W-1:0] ways_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= '0;
         block_bits_ff <= '0;
         ways_used_ff  <= USED_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_data[SETB_W-1:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_data[BLKB_W-1:0];
            CSR_WAYS_USED:  ways_used_ff  <= csr_data[USED_W-1:0];
            default: ;
         endcase
      end
   end

   // fold of the masked set field onto the set count
   logic [SET_W-1:0] set_tab [SET_TAB_N];
   for (genvar i = 0; i < SET_TAB_N; i++) begin : g_set_tab
      assign set_tab[i] = SET_W'(i % SETS);
   end

   // address split
   logic [ADDR_W-1:0]    addr_shr;
   logic [SET_RAW_W-1:0] set_mask;
   logic [SET_RAW_W-1:0] set_raw;
   logic [SET_RAW_W-1:0] tag_shift;
   logic [ADDR_W-1:0]    tag_in;
   logic [SET_W-1:0]     set_in;
   logic [4:0]           used_eff;
   logic [WAYS-1:0]      way_on_in;

   always_comb begin
      addr_shr  = req_address >> block_bits_ff;
      set_mask  = SET_RAW_W'((8'd1 << set_bits_ff) - 8'd1);
      set_raw   = addr_shr[SET_RAW_W-1:0] & set_mask;
      set_in    = set_tab[set_raw];
      tag_shift = SET_RAW_W'(set_bits_ff) + SET_RAW_W'(block_bits_ff);
      tag_in    = tag_shift[6] ? '0 : (req_address >> tag_shift[5:0]);
      // ways in use, clamped to 1..WAYS
      if (ways_used_ff == '0) begin
         used_eff = 5'd1;
      end else if ({1'b0, ways_used_ff} > 5'(WAYS)) begin
         used_eff = 5'(WAYS);
      end else begin
         used_eff = {1'b0, ways_used_ff};
      end
      for (int w = 0; w < WAYS; w++) begin
         way_on_in[w] = (5'(w) < used_eff);
      end
   end

   // per-set row-written flags: an unwritten row reads as all invalid, age zero
   logic [SETS-1:0] row_init_ff;
   logic            row_live_ff;

   // captured transaction
   logic [CMD_W-1:0]  cmd_ff;
   logic [ADDR_W-1:0] tag_ff;
   logic [SET_W-1:0]  set_ff;
   logic [WAYS-1:0]   way_on_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff      <= req_command;
         tag_ff      <= tag_in;
         set_ff      <= set_in;
         way_on_ff   <= way_on_in;
         row_live_ff <= row_init_ff[set_in];
      end
   end

   // set row store
   logic [ROW_W-1:0] row_rd;
   logic [ROW_W-1:0] row_wr;

   sac_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_row_ram (
      .clock (clock),
      .we    (cmd.commit),
      .waddr (set_ff),
      .wdata (row_wr),
      .re    (cmd.capture),
      .raddr (set_in),
      .rdata (row_rd)
   );

   // row unpack
   logic              ent_valid [WAYS];
   logic [AGE_W-1:0]  ent_age   [WAYS];
   logic [ADDR_W-1:0] ent_tag   [WAYS];

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         ent_valid[w] = row_live_ff & row_rd[w*ENTRY_W];
         ent_age[w]   = row_live_ff ? row_rd[w*ENTRY_W+1 +: AGE_W] : '0;
         ent_tag[w]   = row_rd[w*ENTRY_W+1+AGE_W +: ADDR_W];
      end
   end

   // way search: first matching way, first empty way, oldest valid way
   logic             hit_any, empty_any, found;
   logic [WAY_W-1:0] hit_way, empty_way, victim_way;
   logic [AGE_W-1:0] oldest;

   always_comb begin
      hit_any    = 1'b0;
      empty_any  = 1'b0;
      found      = 1'b0;
      hit_way    = '0;
      empty_way  = '0;
      victim_way = '0;
      oldest     = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (way_on_ff[w] & ent_valid[w] & (ent_tag[w] == tag_ff)) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (way_on_ff[w] & ~ent_valid[w]) begin
            empty_any = 1'b1;
            empty_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (way_on_ff[w] & ent_valid[w] & (~found | (ent_age[w] > oldest))) begin
            found      = 1'b1;
            oldest     = ent_age[w];
            victim_way = WAY_W'(w);
         end
      end
   end

   // lookup outcome
   logic             hit_ff, fill_ff, evict_ff;
   logic [WAY_W-1:0] sel_way_ff;

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         hit_ff   <= hit_any;
         fill_ff  <= ~hit_any & empty_any;
         evict_ff <= ~hit_any & ~empty_any;
         priority if (hit_any) begin
            sel_way_ff <= hit_way;
         end else if (empty_any) begin
            sel_way_ff <= empty_way;
         end else begin
            sel_way_ff <= victim_way;
         end
      end
   end

   // row rebuild with true LRU ageing
   logic [AGE_W-1:0] sel_age;

   always_comb begin
      sel_age = ent_age[sel_way_ff];
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == sel_way_ff) begin
            row_wr[w*ENTRY_W]                  = 1'b1;
            row_wr[w*ENTRY_W+1 +: AGE_W]       = '0;
            row_wr[w*ENTRY_W+1+AGE_W +: ADDR_W] = hit_ff ? ent_tag[w] : tag_ff;
         end else begin
            row_wr[w*ENTRY_W]                  = ent_valid[w];
            row_wr[w*ENTRY_W+1 +: AGE_W]       = ent_age[w];
            row_wr[w*ENTRY_W+1+AGE_W +: ADDR_W] = ent_tag[w];
            if (way_on_ff[w] & ent_valid[w] & (fill_ff | (ent_age[w] < sel_age))
                & (ent_age[w] < AGE_MAX)) begin
               row_wr[w*ENTRY_W+1 +: AGE_W] = ent_age[w] + AGE_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_init_ff <= '0;
      end else if (cmd.commit) begin
         row_init_ff[set_ff] <= 1'b1;
      end
   end

   // saturating totals
   logic [CNT_W-1:0] hits_ff, misses_ff, evicts_ff;
   logic [CNT_W-1:0] hits_in, misses_in, evicts_in;
   logic [CNT_W:0]   hits_sum;

   always_comb begin
      hits_sum  = {1'b0, hits_ff} + (CNT_W+1)'(hit_ff)
                  + (CNT_W+1)'(cmd_ff == CMD_MODIFY);
      hits_in   = hits_sum[CNT_W] ? CNT_MAX : hits_sum[CNT_W-1:0];
      misses_in = (~hit_ff & (misses_ff != CNT_MAX)) ? misses_ff + CNT_W'(1) : misses_ff;
      evicts_in = (evict_ff & (evicts_ff != CNT_MAX)) ? evicts_ff + CNT_W'(1) : evicts_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else if (cmd.commit) begin
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         evicts_ff <= evicts_in;
      end
   end

   // response register
   logic rsp_valid_ff;
   logic rsp_hit_ff, rsp_evict_ff;
   logic [CNT_W-1:0] rsp_hits_ff, rsp_misses_ff, rsp_evicts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff    <= hit_ff;
         rsp_evict_ff  <= evict_ff;
         rsp_hits_ff   <= hits_in;
         rsp_misses_ff <= misses_in;
         rsp_evicts_ff <= evicts_in;
      end
   end

   assign status.out_busy     = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_was_hit         = rsp_hit_ff;
   assign rsp_was_eviction    = rsp_evict_ff;
   assign rsp_total_hits      = rsp_hits_ff;
   assign rsp_total_misses    = rsp_misses_ff;
   assign rsp_total_evictions = rsp_evicts_ff;

endmodule : sac_dp

`default_nettype wire

[rtl/set_assoc_lru_cache_sim_top.sv]
// Top level of the set-associative LRU cache simulator.
// Depends on sac_pkg, sac_ctrl, sac_dp and sac_ram.
`timescale 1ns / 1ps
`default_nettype none

// Takes one memory access per request transaction (tuser: command, tdata: address)
// and returns one response with the hit and eviction flags and the running hit,
// miss and eviction totals, all saturating at all ones. For each access the set row
// is read from the row RAM at the accepting edge, the ways are searched in the next
// cycle, and the row is then written back with updated recency, which also loads
// the response. The write-back edge also presents the response and makes the
// request channel ready again, so one access is in flight at a time. The next
// request is accepted while an earlier response still waits; its write-back
// stalls only until that response is taken. Reset clears all lines at once
// through per-set flags, with no sweep. Registers are written through the csr
// channel, which is always ready, and are meant to change only while the block
// is idle.
module set_assoc_lru_cache_sim_top
   import sac_pkg::*;
#(
   parameter int SETS = SETS_DEF,
   parameter int WAYS = WAYS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [63:0]           req_tdata,   // address[63:0]
   input  wire logic [1:0]            req_tuser,   // command[1:0]
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [95:0]                rsp_tdata,   // total_hits, total_misses, total_evictions
   output logic [1:0]                 rsp_tuser,   // was_hit, was_eviction
   // register write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          rsp_hit, rsp_evict;
   logic [CNT_W-1:0] rsp_hits, rsp_misses, rsp_evicts;

   // sequencing
   sac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // lookup and update datapath
   sac_dp #(
      .SETS (SETS),
      .WAYS (WAYS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_command         (req_tuser),
      .req_address         (req_tdata),
      .rsp_valid           (rsp_tvalid),
      .rsp_ready           (rsp_tready),
      .rsp_was_hit         (rsp_hit),
      .rsp_was_eviction    (rsp_evict),
      .rsp_total_hits      (rsp_hits),
      .rsp_total_misses    (rsp_misses),
      .rsp_total_evictions (rsp_evicts),
      .cmd                 (cmd),
      .status              (status)
   );

   // response packing
   assign rsp_tdata = {rsp_evicts, rsp_misses, rsp_hits};
   assign rsp_tuser = {rsp_evict, rsp_hit};
   assign csr_ready = 1'b1;

endmodule : set_assoc_lru_cache_sim_top

`default_nettype wire
